@@ sv/nse_pkg.sv @@
// ----------------------------------------------------------------------------
// nse_pkg
// Types and codes shared by the next-smaller-element stream modules.
// ----------------------------------------------------------------------------
package nse_pkg;

  typedef enum logic [1:0] {
    ST_FOUND   = 2'd0,
    ST_NONE    = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FREAD,
    S_FPOP,
    S_FIN
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    load;       // capture the accepted input beat
    logic    produce;    // stage a new result in the hold register
    status_t kind;       // status of the staged result
    logic    pop;        // drop the top stack entry
    logic    push;       // write the current item on top of the stack
    logic    send_last;  // move the hold register out, marked last
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic greater;     // stack not empty and top strictly greater than item
    logic empty;
    logic full;
    logic hold_valid;
    logic slot_free;   // output register free or being taken this cycle
    logic last;        // current item ends its sequence
  } sts_t;

endpackage

@@ sv/nse_ram.sv @@
// ----------------------------------------------------------------------------
// nse_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module nse_ram #(
  parameter int WIDTH = 44,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/nse_ctrl.sv @@
// ----------------------------------------------------------------------------
// nse_ctrl
// Sequencer for the stack: compare, pop, push or drop, flush, final hand-off.
// ----------------------------------------------------------------------------
module nse_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  nse_pkg::sts_t   sts,
  output nse_pkg::cmd_t   cmd
);

  nse_pkg::state_t state, state_next;
  logic            can_prod;

  assign can_prod = !sts.hold_valid || sts.slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nse_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nse_pkg::S_IDLE: begin
        if (in_valid) state_next = nse_pkg::S_CMP;
      end
      nse_pkg::S_READ: begin
        state_next = nse_pkg::S_CMP;
      end
      nse_pkg::S_CMP: begin
        if (sts.greater) begin
          if (can_prod) state_next = nse_pkg::S_READ;
        end else if (!sts.full || can_prod) begin
          state_next = sts.last ? nse_pkg::S_FREAD : nse_pkg::S_FIN;
        end
      end
      nse_pkg::S_FREAD: begin
        state_next = sts.empty ? nse_pkg::S_FIN : nse_pkg::S_FPOP;
      end
      nse_pkg::S_FPOP: begin
        if (can_prod) state_next = nse_pkg::S_FREAD;
      end
      nse_pkg::S_FIN: begin
        if (!sts.hold_valid || sts.slot_free) state_next = nse_pkg::S_IDLE;
      end
      default: state_next = nse_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.kind = nse_pkg::ST_FOUND;
    in_ready = 1'b0;
    unique case (state)
      nse_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      nse_pkg::S_READ: ;
      nse_pkg::S_CMP: begin
        if (sts.greater) begin
          cmd.produce = can_prod;
          cmd.pop     = can_prod;
        end else if (!sts.full) begin
          cmd.push = 1'b1;
        end else begin
          // still full after the pops: report the item as dropped
          cmd.produce = can_prod;
          cmd.kind    = nse_pkg::ST_DROPPED;
        end
      end
      nse_pkg::S_FREAD: ;
      nse_pkg::S_FPOP: begin
        cmd.produce = can_prod;
        cmd.pop     = can_prod;
        cmd.kind    = nse_pkg::ST_NONE;
      end
      nse_pkg::S_FIN: begin
        cmd.send_last = sts.hold_valid && sts.slot_free;
      end
      default: ;
    endcase
  end

endmodule

@@ sv/nse_dp.sv @@
// ----------------------------------------------------------------------------
// nse_dp
// Stack RAM, stack count, position counter, result hold and output register.
// ----------------------------------------------------------------------------
module nse_dp #(
  parameter int STACK_DEPTH = 32,
  parameter int MAX_LEN     = 4096,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  nse_pkg::cmd_t          cmd,
  output nse_pkg::sts_t          sts,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   last_of_sequence,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [11:0]            element_index,
  output logic [VALUE_WIDTH-1:0] element_value,
  output logic [VALUE_WIDTH-1:0] next_smaller,
  output logic [1:0]             status,
  output logic                   last_result
);

  localparam int PW = $clog2(MAX_LEN);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = VALUE_WIDTH + PW;

  logic [CW-1:0]          count;
  logic [PW-1:0]          pos_count;
  logic [VALUE_WIDTH-1:0] cur_val;
  logic [PW-1:0]          cur_pos;
  logic                   cur_last;

  logic [EW-1:0]          rd_data;
  logic [VALUE_WIDTH-1:0] top_val;
  logic [PW-1:0]          top_pos;
  logic [CW-1:0]          count_dec;

  logic                   hold_valid;
  logic [PW-1:0]          hold_pos;
  logic [VALUE_WIDTH-1:0] hold_val;
  logic [VALUE_WIDTH-1:0] hold_nxt;
  nse_pkg::status_t       hold_st;

  assign count_dec = count - CW'(1);
  assign top_val   = rd_data[EW-1:PW];
  assign top_pos   = rd_data[PW-1:0];

  nse_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (count[AW-1:0]),
    .wdata ({cur_val, cur_pos}),
    .raddr (count_dec[AW-1:0]),
    .rdata (rd_data)
  );

  assign sts.empty      = (count == '0);
  assign sts.full       = (count == CW'(STACK_DEPTH));
  assign sts.greater    = !sts.empty && ($signed(top_val) > $signed(cur_val));
  assign sts.hold_valid = hold_valid;
  assign sts.slot_free  = !out_valid || out_ready;
  assign sts.last       = cur_last;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      pos_count  <= '0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (last_of_sequence || pos_count == PW'(MAX_LEN - 1)) begin
          pos_count <= '0;
        end else begin
          pos_count <= pos_count + PW'(1);
        end
      end
      if (cmd.pop) begin
        count <= count_dec;
      end else if (cmd.push) begin
        count <= count + CW'(1);
      end
      if (cmd.produce) begin
        hold_valid <= 1'b1;
      end else if (cmd.send_last) begin
        hold_valid <= 1'b0;
      end
      if ((cmd.produce && hold_valid) || cmd.send_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_val  <= value;
      cur_pos  <= pos_count;
      cur_last <= last_of_sequence;
    end
    if (cmd.produce) begin
      hold_st <= cmd.kind;
      if (cmd.kind == nse_pkg::ST_DROPPED) begin
        hold_pos <= cur_pos;
        hold_val <= cur_val;
      end else begin
        hold_pos <= top_pos;
        hold_val <= top_val;
      end
      hold_nxt <= (cmd.kind == nse_pkg::ST_FOUND) ? cur_val : '0;
    end
    // a new result behind the held one means the held one is not last
    if ((cmd.produce && hold_valid) || cmd.send_last) begin
      element_index <= 12'(hold_pos);
      element_value <= hold_val;
      next_smaller  <= hold_nxt;
      status        <= hold_st;
      last_result   <= cmd.send_last;
    end
  end

endmodule

@@ sv/next_smaller_element_stream.sv @@
// ----------------------------------------------------------------------------
// next_smaller_element_stream
// Monotonic-stack next-smaller-element finder over a stream of signed values.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one beat per element, value plus
// last_of_sequence on the final element of a sequence. Output channel
// (out_valid/out_ready): one beat per answered element, with its index,
// its value, the next strictly smaller value and a status (found, none
// before the sequence end, dropped because the stack was full).
// last_result marks the final output beat caused by one input beat.
// An input beat that pops nothing, is not dropped and does not end a
// sequence gives no output.
// Each input beat passes S_IDLE, S_CMP and S_FIN; each popped entry adds
// S_READ and S_CMP, each entry flushed at sequence end adds S_FREAD and
// S_FPOP, and an item that ends its sequence adds a last S_FREAD; a dropped
// item adds no state. The stack RAM has one registered read port, so each
// pop waits in S_READ for the new top. Results pass through a one-deep hold
// stage and an output register, so a result leaves once the next is known.
// When the receiver stalls, the block runs on until it needs the output
// register, then waits; no result is lost.
// Reset empties the stack (count to zero, no clearing pass) and sets the
// position counter to zero; input is taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module next_smaller_element_stream #(
  parameter int STACK_DEPTH = 32,
  parameter int MAX_LEN     = 4096,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [VALUE_WIDTH-1:0] value,
  input  logic                   last_of_sequence,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [11:0]            element_index,
  output logic [VALUE_WIDTH-1:0] element_value,
  output logic [VALUE_WIDTH-1:0] next_smaller,
  output logic [1:0]             status,
  output logic                   last_result
);

  nse_pkg::cmd_t cmd;
  nse_pkg::sts_t sts;

  nse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nse_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .MAX_LEN     (MAX_LEN),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .value            (value),
    .last_of_sequence (last_of_sequence),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .element_index    (element_index),
    .element_value    (element_value),
    .next_smaller     (next_smaller),
    .status           (status),
    .last_result      (last_result)
  );

  a_idle_no_hold: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !sts.hold_valid)
    else $error("result left in hold while accepting input");

  a_produce_room: assert property (@(posedge clk) disable iff (rst)
    cmd.produce |-> (!sts.hold_valid || sts.slot_free))
    else $error("held result overwritten");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> !sts.empty)
    else $error("pop from empty stack");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!sts.full && !cmd.pop))
    else $error("push onto full stack");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks next_smaller_element_stream against an in-bench monotonic-stack
// predictor. A short table of hand-picked beats comes first, then random
// sequences (ramps that can overrun the stack, runs of equal values, full-range
// values, lone final beats). Both channels idle at random, and the receiver
// freezes once for a long stretch so that the input side stalls.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DEPTH      = 32;
  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = 40;
  localparam int RAND_ITEMS = 200;

  typedef struct {
    logic [11:0]      idx;
    logic [31:0]      val;
    logic [31:0]      nxt;
    nse_pkg::status_t st;
    logic             fin;
  } answer_t;

  typedef struct {
    logic [31:0] v;
    logic        l;
    bit          typed;
    answer_t     ans;
  } step_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] value;
  logic        last_of_sequence;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] element_index;
  logic [31:0] element_value;
  logic [31:0] next_smaller;
  logic [1:0]  status;
  logic        last_result;

  // predictor state
  logic [31:0] stk_val [DEPTH];
  logic [11:0] stk_pos [DEPTH];
  int          stk_fill;
  logic [11:0] next_pos;
  answer_t     fresh[$];
  answer_t     answers_due[$];
  step_t       steps[$];

  bit tx_calm;
  bit rx_calm;
  bit hold_req;

  int errors;
  int n_items;
  int n_seqs;
  int n_checked;
  int n_dropped;
  int max_fill;
  int n_holds;

  next_smaller_element_stream u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .value            (value),
    .last_of_sequence (last_of_sequence),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .element_index    (element_index),
    .element_value    (element_value),
    .next_smaller     (next_smaller),
    .status           (status),
    .last_result      (last_result)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Pop every strictly greater entry, push or drop, flush on the final beat.
  function automatic void work_out(logic [31:0] v, logic l);
    answer_t a;
    fresh.delete();
    while (stk_fill > 0 && $signed(stk_val[stk_fill-1]) > $signed(v)) begin
      stk_fill--;
      a.idx = stk_pos[stk_fill];
      a.val = stk_val[stk_fill];
      a.nxt = v;
      a.st  = nse_pkg::ST_FOUND;
      a.fin = 1'b0;
      fresh.push_back(a);
    end
    if (stk_fill < DEPTH) begin
      stk_val[stk_fill] = v;
      stk_pos[stk_fill] = next_pos;
      stk_fill++;
      if (stk_fill > max_fill) max_fill = stk_fill;
    end else begin
      a.idx = next_pos;
      a.val = v;
      a.nxt = '0;
      a.st  = nse_pkg::ST_DROPPED;
      a.fin = 1'b0;
      fresh.push_back(a);
      n_dropped++;
    end
    if (l) begin
      while (stk_fill > 0) begin
        stk_fill--;
        a.idx = stk_pos[stk_fill];
        a.val = stk_val[stk_fill];
        a.nxt = '0;
        a.st  = nse_pkg::ST_NONE;
        a.fin = 1'b0;
        fresh.push_back(a);
      end
      next_pos = '0;
      n_seqs++;
    end else begin
      next_pos = next_pos + 12'd1;
    end
    if (fresh.size() > 0) fresh[fresh.size()-1].fin = 1'b1;
  endfunction

  function automatic void add_step(logic [31:0] v, logic l, bit typed = 1'b0,
                                   logic [11:0] idx = '0, logic [31:0] val = '0,
                                   logic [31:0] nxt = '0,
                                   nse_pkg::status_t st = nse_pkg::ST_FOUND);
    step_t s;
    s.v = v;
    s.l = l;
    s.typed = typed;
    s.ans.idx = idx;
    s.ans.val = val;
    s.ans.nxt = nxt;
    s.ans.st  = st;
    s.ans.fin = 1'b1;
    steps.push_back(s);
  endfunction

  // Offer one beat; called and returning at a rising edge.
  task automatic offer(input step_t s);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    value            <= s.v;
    last_of_sequence <= s.l;
    do @(posedge clk); while (!in_ready);
    work_out(s.v, s.l);
    if (s.typed) answers_due.push_back(s.ans);
    else foreach (fresh[i]) answers_due.push_back(fresh[i]);
    n_items++;
  endtask

  task automatic offer_plain(input logic [31:0] v, input logic l);
    step_t s;
    s.v = v;
    s.l = l;
    s.typed = 1'b0;
    s.ans.idx = '0;
    s.ans.val = '0;
    s.ans.nxt = '0;
    s.ans.st  = nse_pkg::ST_FOUND;
    s.ans.fin = 1'b0;
    offer(s);
  endtask

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    answer_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (answers_due.size() == 0) begin
        $display("%0t: result with nothing awaited, expected none, got index %0d value %h",
                 $realtime, element_index, element_value);
        errors++;
      end else begin
        want = answers_due.pop_front();
        check_field("element_index", want.idx, element_index);
        check_field("element_value", want.val, element_value);
        check_field("next_smaller", want.nxt, next_smaller);
        check_field("status", want.st, status);
        check_field("last_result", want.fin, last_result);
        n_checked++;
      end
    end
  end

  initial begin : receiver
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // freeze long enough for the block to fill and stall its input
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        n_holds++;
      end else begin
        gap = rx_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin : stimulus
    int kind;
    int len;
    int rand_items;
    logic [31:0] v;
    logic [31:0] stride;
    bit pop_all;
    $timeformat(-9, 1, " ns", 0);
    rst = 1'b1;
    in_valid = 1'b0;
    value = '0;
    last_of_sequence = 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_req = 1'b0;
    stk_fill = 0;
    next_pos = '0;
    errors = 0;
    n_items = 0;
    n_seqs = 0;
    n_checked = 0;
    n_dropped = 0;
    max_fill = 0;
    n_holds = 0;

    // extremes, equal values, single-entry flushes, multi-pop beats
    add_step(32'd5, 1'b0);
    add_step(32'd3, 1'b0, 1'b1, 12'd0, 32'd5, 32'd3, nse_pkg::ST_FOUND);
    add_step(32'd3, 1'b0);
    add_step(32'h7FFF_FFFF, 1'b0);
    add_step(32'h7FFF_FFFF, 1'b0);
    add_step(32'h8000_0000, 1'b1);
    add_step(32'd0, 1'b1, 1'b1, 12'd0, 32'd0, 32'd0, nse_pkg::ST_NONE);
    add_step(32'h8000_0000, 1'b0);
    add_step(32'h8000_0000, 1'b0);
    add_step(32'h7FFF_FFFF, 1'b1);
    add_step(32'hFFFF_FFFF, 1'b0);
    add_step(32'd0, 1'b0);
    add_step(32'd1, 1'b0);
    add_step(32'hFFFF_FFFE, 1'b0);
    add_step(32'hFFFF_FFFF, 1'b1);
    add_step(32'h1234_5678, 1'b1, 1'b1, 12'd0, 32'h1234_5678, 32'd0, nse_pkg::ST_NONE);
    add_step(32'hAAAA_AAAA, 1'b0);
    add_step(32'h5555_5555, 1'b0);
    add_step(32'd1, 1'b1);
    add_step(32'h8000_0001, 1'b0);
    add_step(32'h8000_0000, 1'b1);
    add_step(32'h7FFF_FFFE, 1'b1, 1'b1, 12'd0, 32'h7FFF_FFFE, 32'd0, nse_pkg::ST_NONE);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (steps[i]) offer(steps[i]);

    hold_req = 1'b1;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      kind = $urandom_range(0, 9);
      tx_calm = ($urandom_range(0, 3) == 0);
      if (kind <= 3) begin
        len = $urandom_range(1, 12);
        for (int k = 0; k < len; k++) offer_plain($urandom, k == len - 1);
      end else if (kind <= 5) begin
        // narrow range: many equal neighbours
        len = $urandom_range(1, 10);
        for (int k = 0; k < len; k++)
          offer_plain($urandom_range(0, 6) - 3, k == len - 1);
      end else if (kind <= 7) begin
        // non-decreasing ramp, often long enough to overrun the stack
        len = $urandom_range(30, 40);
        v = $urandom_range(0, 4000) - 2000;
        pop_all = $urandom_range(0, 1);
        for (int k = 0; k < len - 1; k++) begin
          offer_plain(v, 1'b0);
          stride = $urandom_range(0, 3);
          v = v + stride;
        end
        offer_plain(pop_all ? 32'h8000_0000 : v, 1'b1);
      end else if (kind == 8) begin
        len = $urandom_range(2, 8);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 4))
            0: v = 32'h7FFF_FFFF;
            1: v = 32'h8000_0000;
            2: v = 32'd0;
            3: v = 32'hFFFF_FFFF;
            default: v = $urandom;
          endcase
          offer_plain(v, k == len - 1);
        end
      end else begin
        len = 1;
        offer_plain($urandom, 1'b1);
      end
      rand_items += len;
    end
    in_valid <= 1'b0;

    while (answers_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d beats over %0d sequences, %0d results checked,",
             n_items, n_seqs, n_checked);
    $display("%0d drops on a full stack, deepest stack %0d, %0d long receiver freeze(s).",
             n_dropped, max_fill, n_holds);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d results still awaited", answers_due.size());
    $display("Verification failed");
    $finish;
  end

endmodule
